// ===== src/sas_pkg.sv =====
package sas_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_SORT    = 3'd2,
    CMD_REVERSE = 3'd3,
    CMD_READ    = 3'd4,
    CMD_WRITE   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD     = 3'd0,
    CELL_LOAD     = 3'd1,
    CELL_INIT_TAG = 3'd2,
    CELL_SORT     = 3'd3,
    CELL_REVERSE  = 3'd4
  } cell_op_e;

  typedef enum logic [1:0] {
    CTRL_IDLE    = 2'd0,
    CTRL_SORT    = 2'd1,
    CTRL_REVERSE = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    cell_op_e op;
    logic     phase;
  } cell_ctl_t;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned PosW   = 6;
  localparam int unsigned CountW = 7;

endpackage

// ===== src/sas_cell.sv =====
module sas_cell #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned INDEX    = 0,
  localparam int unsigned CW = $clog2(CAPACITY + 1),
  localparam int unsigned TW = $clog2(CAPACITY)
) (
  input  logic                                clk_i,
  input  sas_pkg::cell_ctl_t                  ctl_i,
  input  logic [CW-1:0]                       count_i,
  input  logic [CW-1:0]                       target_i,
  input  logic signed [sas_pkg::WordW-1:0]    value_i,
  input  logic signed [sas_pkg::WordW-1:0]    left_word_i,
  input  logic [TW-1:0]                       left_tag_i,
  input  logic signed [sas_pkg::WordW-1:0]    right_word_i,
  input  logic [TW-1:0]                       right_tag_i,
  output logic signed [sas_pkg::WordW-1:0]    word_o,
  output logic [TW-1:0]                       tag_o,
  output logic [sas_pkg::WordW-1:0]           hit_o
);

  localparam logic [CW-1:0] Idx   = CW'(INDEX);
  localparam logic [CW:0]   IdxP1 = (CW + 1)'(INDEX + 1);
  localparam logic [TW-1:0] Tag0  = TW'(INDEX);

  logic signed [sas_pkg::WordW-1:0] word_q, word_d;
  logic [TW-1:0]                    tag_q, tag_d;
  logic                             is_low, active, swap;

  always_comb begin
    is_low = (Idx[0] == ctl_i.phase);
    if (is_low) begin
      active = (IdxP1 < {1'b0, count_i});
    end else begin
      active = (INDEX >= 1) && (Idx < count_i);
    end
    swap = 1'b0;
    if (ctl_i.op == sas_pkg::CELL_SORT) begin
      swap = is_low ? (word_q > right_word_i) : (left_word_i > word_q);
    end else if (ctl_i.op == sas_pkg::CELL_REVERSE) begin
      swap = is_low ? (tag_q < right_tag_i) : (left_tag_i < tag_q);
    end
    swap = swap && active;

    word_d = word_q;
    tag_d  = tag_q;
    unique case (ctl_i.op)
      sas_pkg::CELL_LOAD: begin
        if (Idx == target_i) begin
          word_d = value_i;
        end
      end
      sas_pkg::CELL_INIT_TAG: begin
        tag_d = Tag0;
      end
      sas_pkg::CELL_SORT, sas_pkg::CELL_REVERSE: begin
        if (swap) begin
          word_d = is_low ? right_word_i : left_word_i;
          tag_d  = is_low ? right_tag_i : left_tag_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    tag_q  <= tag_d;
  end

  assign word_o = word_q;
  assign tag_o  = tag_q;
  assign hit_o  = (Idx == target_i) ? word_q : '0;

endmodule

// ===== src/sas_ctrl.sv =====
module sas_ctrl #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic               sort_start_i,
  input  logic               rev_start_i,
  input  logic [CW-1:0]      count_i,
  output sas_pkg::cell_ctl_t ctl_o,
  output logic               busy_o
);

  sas_pkg::ctrl_state_e state_q, state_d;
  logic [CW-1:0]        rounds_q, rounds_d;
  logic                 phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sas_pkg::CTRL_IDLE;
      rounds_q <= '0;
      phase_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rounds_q <= rounds_d;
      phase_q  <= phase_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    rounds_d    = rounds_q;
    phase_d     = phase_q;
    ctl_o.op    = sas_pkg::CELL_HOLD;
    ctl_o.phase = phase_q;
    unique case (state_q)
      sas_pkg::CTRL_IDLE: begin
        if (load_i) begin
          ctl_o.op = sas_pkg::CELL_LOAD;
        end else if (sort_start_i) begin
          state_d  = sas_pkg::CTRL_SORT;
          rounds_d = count_i;
          phase_d  = 1'b0;
        end else if (rev_start_i) begin
          ctl_o.op = sas_pkg::CELL_INIT_TAG;
          state_d  = sas_pkg::CTRL_REVERSE;
          rounds_d = count_i;
          phase_d  = 1'b0;
        end
      end
      sas_pkg::CTRL_SORT, sas_pkg::CTRL_REVERSE: begin
        ctl_o.op = (state_q == sas_pkg::CTRL_SORT) ? sas_pkg::CELL_SORT
                                                   : sas_pkg::CELL_REVERSE;
        rounds_d = rounds_q - 1'b1;
        phase_d  = ~phase_q;
        if (rounds_q <= CW'(1)) begin
          state_d = sas_pkg::CTRL_IDLE;
        end
      end
      default: state_d = sas_pkg::CTRL_IDLE;
    endcase
  end

  assign busy_o = (state_q != sas_pkg::CTRL_IDLE);

endmodule

// ===== src/sortable_array_store.sv =====
// Push, pop, read and write give their result in the cycle after the transfer and
// accept one item per cycle while the input is not stalled.
// Sort and reverse give their result in the cycle after the transfer; with two or more
// words in use they then hold the input stalled for odd-even transposition rounds
// over the cell row, and with fewer words they do not stall the input.
// Reset clears the word count and the controller; stored words stay undefined
// until written, and there is no clearing pass.
module sortable_array_store #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [sas_pkg::CmdW-1:0]         command_i,
  input  logic signed [sas_pkg::WordW-1:0] value_i,
  input  logic [sas_pkg::PosW-1:0]         position_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [sas_pkg::CountW-1:0]       count_o,
  output logic signed [sas_pkg::WordW-1:0] data_o,
  output logic [1:0]                       status_o
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned TW   = $clog2(CAPACITY);
  localparam int unsigned CmpW = (CW > sas_pkg::PosW) ? CW : sas_pkg::PosW;
  localparam logic [CW-1:0] Full = CW'(CAPACITY);

  logic [CW-1:0]   count_q, count_d;
  logic            out_valid_q;
  logic [sas_pkg::CountW-1:0]       out_count_q;
  logic signed [sas_pkg::WordW-1:0] out_data_q, data_d;
  sas_pkg::status_e                 out_status_q, status_d;

  logic            accept, busy, pos_ok, rd_sel, load, sort_start, rev_start;
  logic [CW-1:0]   target;
  sas_pkg::cmd_e   cmd;
  sas_pkg::cell_ctl_t ctl;

  logic signed [sas_pkg::WordW-1:0] cell_word [CAPACITY];
  logic [TW-1:0]                    cell_tag  [CAPACITY];
  logic [sas_pkg::WordW-1:0]        cell_hit  [CAPACITY];
  logic [sas_pkg::WordW-1:0]        rd_or;

  assign in_stall_o = busy | (out_valid_q & out_stall_i);
  assign accept     = in_valid_i & ~in_stall_o;
  assign cmd        = sas_pkg::cmd_e'(command_i);
  assign pos_ok     = (CmpW'(position_i) < CmpW'(count_q));
  assign target     = (cmd == sas_pkg::CMD_PUSH) ? count_q : CW'(position_i);

  always_comb begin
    count_d    = count_q;
    status_d   = sas_pkg::STATUS_OK;
    rd_sel     = 1'b0;
    load       = 1'b0;
    sort_start = 1'b0;
    rev_start  = 1'b0;
    if (accept) begin
      unique case (cmd)
        sas_pkg::CMD_PUSH: begin
          if (count_q == Full) begin
            status_d = sas_pkg::STATUS_FULL;
          end else begin
            load    = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        sas_pkg::CMD_POP: begin
          if (count_q == '0) begin
            status_d = sas_pkg::STATUS_EMPTY;
          end else begin
            count_d = count_q - 1'b1;
          end
        end
        sas_pkg::CMD_SORT:    sort_start = (count_q >= CW'(2));
        sas_pkg::CMD_REVERSE: rev_start  = (count_q >= CW'(2));
        sas_pkg::CMD_READ: begin
          if (pos_ok) begin
            rd_sel = 1'b1;
          end else begin
            status_d = sas_pkg::STATUS_RANGE;
          end
        end
        sas_pkg::CMD_WRITE: begin
          if (pos_ok) begin
            load = 1'b1;
          end else begin
            status_d = sas_pkg::STATUS_RANGE;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    rd_or = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_or = rd_or | cell_hit[k];
    end
  end

  assign data_d = rd_sel ? $signed(rd_or) : '0;

  sas_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .sort_start_i(sort_start),
    .rev_start_i (rev_start),
    .count_i     (count_q),
    .ctl_o       (ctl),
    .busy_o      (busy)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [sas_pkg::WordW-1:0] left_word, right_word;
    logic [TW-1:0]                    left_tag, right_tag;

    if (g == 0) begin : g_first
      assign left_word = '0;
      assign left_tag  = '0;
    end else begin : g_mid_l
      assign left_word = cell_word[g-1];
      assign left_tag  = cell_tag[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_word = '0;
      assign right_tag  = '0;
    end else begin : g_mid_r
      assign right_word = cell_word[g+1];
      assign right_tag  = cell_tag[g+1];
    end

    sas_cell #(
      .CAPACITY(CAPACITY),
      .INDEX   (g)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .count_i     (count_q),
      .target_i    (target),
      .value_i     (value_i),
      .left_word_i (left_word),
      .left_tag_i  (left_tag),
      .right_word_i(right_word),
      .right_tag_i (right_tag),
      .word_o      (cell_word[g]),
      .tag_o       (cell_tag[g]),
      .hit_o       (cell_hit[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_count_q  <= sas_pkg::CountW'(count_d);
      out_data_q   <= data_d;
      out_status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign count_o     = out_count_q;
  assign data_o      = out_data_q;
  assign status_o    = out_status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("word count exceeds capacity");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> in_stall_o)
    else $error("input taken while the cell row is busy");

  a_flag_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status_d != sas_pkg::STATUS_OK) |=> count_q == $past(count_q))
    else $error("flagged transfer changed the word count");

  a_sort_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sort_start || rev_start) |=> busy && count_q == $past(count_q))
    else $error("sort or reverse did not start the cell row");

endmodule
